// ===== hdl/banded_path_count_mod_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef BANDED_PATH_COUNT_MOD_MACROS_SVH
`define BANDED_PATH_COUNT_MOD_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bpc_pkg.sv =====
`default_nettype none

package bpc_pkg;

	localparam int COUNT_W = 30;
	localparam int VALUE_W = 8;

	// Prime modulus and its double, used by the reduction stages
	localparam logic [COUNT_W-1:0] MODULUS    = 30'd1000000007;
	localparam logic [COUNT_W:0]   MODULUS_X2 = 31'd2000000014;

	localparam logic [VALUE_W-1:0] MAX_VALUE_RST = 8'd128;

	// Row sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE0,
		ST_PRE1,
		ST_SWEEP,
		ST_DRAIN
	} bpc_state_t;

endpackage

`default_nettype wire

// ===== hdl/banded_path_count_mod.sv =====
// Channel   Dir  Payload                         Transaction ends when
// s_*       in   tdata[7:0] value, tlast last    s_tvalid && s_tready
// m_*       out  tdata[29:0] count               m_tvalid && m_tready
// cfg_*     in   cfg_wr_data max_value           cfg_wr_en high
//
// Each accepted transaction sweeps the whole row of MAX_VALUES counts, one count
// per cycle through a one-read one-write row memory and one modular adder pipeline.
// s_tready is high only in the idle state, so an item waits until the previous one drains.
// The result sits in an output register; a last item that finds it still full
// holds in the drain state until the previous count is taken.
// arst_n resets sequencer, band, output valid; each array's first item rewrites the row.
`default_nettype none

module banded_path_count_mod #(
	parameter int MAX_VALUES = 128
) (
	input  wire         clk,
	input  wire         arst_n,
	// value [7:0]
	input  wire  [7:0]  s_tdata,
	input  wire         s_tlast,
	input  wire         s_tvalid,
	output logic        s_tready,
	// count [29:0], zeros [31:30]
	output logic [31:0] m_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	input  wire         cfg_wr_en,
	input  wire  [7:0]  cfg_wr_data
);

	import bpc_pkg::*;

	localparam int KW = $clog2(MAX_VALUES);
	localparam int CW = (KW + 1 > 9) ? KW + 1 : 9;
	localparam logic [CW-1:0] ROW_LEN = CW'(MAX_VALUES);
	localparam logic [KW-1:0] LAST_K  = KW'(MAX_VALUES - 1);

	bpc_state_t state_q, state_d;

	logic [KW-1:0]        k_q;
	logic                 first_q;
	logic [VALUE_W-1:0]   max_value_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 last_q;

	logic [COUNT_W-1:0]   ways_mem [MAX_VALUES];
	logic [COUNT_W-1:0]   rd_q, prev_q, cur_q;
	logic                 rd_en;
	logic [KW-1:0]        rd_addr;

	logic [COUNT_W+1:0]   sum_s1;
	logic                 keep_s1;
	logic [KW-1:0]        addr_s1;
	logic                 vld_s1;
	logic [COUNT_W-1:0]   wdat_s2;
	logic                 vld_s2;
	logic [COUNT_W-1:0]   acc_q;
	logic [COUNT_W-1:0]   out_q;
	logic                 out_valid_q;

	logic                 accept, sweep, drain_done, load_pre1;
	logic [CW-1:0]        k_ext, k_next, k_ahead, band;
	logic                 in_band, nbr_in, keep;
	logic [COUNT_W+1:0]   raw_sum;
	logic [COUNT_W-1:0]   red, acc_red;
	logic [COUNT_W:0]     acc_sum;

	// Index arithmetic in a width that holds both the row length and the band
	assign k_ext   = CW'(k_q);
	assign k_next  = k_ext + CW'(1);
	assign k_ahead = k_ext + CW'(2);
	assign band    = CW'(max_value_q);

	// Band and fixed-value masks for the current count
	assign in_band = k_ext < band;
	assign nbr_in  = (k_next < band) && (k_next < ROW_LEN);
	assign keep    = in_band && ((value_q == '0) || (k_next == CW'(value_q)));

	// Three-term sum, or a seed of one on the first entry
	always_comb begin
		if (first_q) begin
			raw_sum = (COUNT_W+2)'(1);
		end else begin
			raw_sum = {2'b00, prev_q} + {2'b00, cur_q}
				+ (nbr_in ? {2'b00, rd_q} : '0);
		end
	end

	// Reduce the registered sum below the modulus and apply the mask
	always_comb begin
		if (!keep_s1) begin
			red = '0;
		end else if (sum_s1 >= (COUNT_W+2)'(MODULUS_X2)) begin
			red = COUNT_W'(sum_s1 - (COUNT_W+2)'(MODULUS_X2));
		end else if (sum_s1 >= (COUNT_W+2)'(MODULUS)) begin
			red = COUNT_W'(sum_s1 - (COUNT_W+2)'(MODULUS));
		end else begin
			red = COUNT_W'(sum_s1);
		end
	end

	// Running row total for the emitted count
	assign acc_sum = {1'b0, acc_q} + {1'b0, wdat_s2};
	always_comb begin
		if (acc_sum >= (COUNT_W+1)'(MODULUS)) begin
			acc_red = COUNT_W'(acc_sum - (COUNT_W+1)'(MODULUS));
		end else begin
			acc_red = COUNT_W'(acc_sum);
		end
	end

	assign drain_done = (state_q == ST_DRAIN) && !vld_s1 && !vld_s2
		&& (!last_q || !out_valid_q || m_tready);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_PRE0;
			end
			ST_PRE0:  state_d = ST_PRE1;
			ST_PRE1:  state_d = ST_SWEEP;
			ST_SWEEP: begin
				if (k_q == LAST_K) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drain_done) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs and memory read address
	always_comb begin
		s_tready  = 1'b0;
		sweep     = 1'b0;
		load_pre1 = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_PRE0:  rd_en = 1'b1;
			ST_PRE1: begin
				load_pre1 = 1'b1;
				rd_en     = 1'b1;
				rd_addr   = KW'(1);
			end
			ST_SWEEP: begin
				sweep   = 1'b1;
				rd_en   = k_ahead < ROW_LEN;
				rd_addr = k_ahead[KW-1:0];
			end
			default: ;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			first_q     <= 1'b1;
			max_value_q <= MAX_VALUE_RST;
			out_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= sweep;
			vld_s2  <= vld_s1;
			if (cfg_wr_en) max_value_q <= cfg_wr_data;
			if (load_pre1) begin
				k_q <= '0;
			end else if (sweep) begin
				k_q <= k_q + KW'(1);
			end
			if (drain_done && last_q) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (drain_done) first_q <= last_q;
		end
	end

	// Row memory: write behind, read ahead
	always_ff @(posedge clk) begin
		if (vld_s1) ways_mem[addr_s1] <= red;
		if (rd_en) rd_q <= ways_mem[rd_addr];
	end

	// Payload and pipeline registers
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= s_tdata;
			last_q  <= s_tlast;
			acc_q   <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_red;
		end
		if (load_pre1) begin
			prev_q <= '0;
			cur_q  <= rd_q;
		end else if (sweep) begin
			prev_q <= cur_q;
			cur_q  <= rd_q;
		end
		sum_s1  <= raw_sum;
		keep_s1 <= keep;
		addr_s1 <= k_q;
		wdat_s2 <= red;
		if (drain_done && last_q) out_q <= acc_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q};

endmodule

`default_nettype wire

// ===== hdl/bpc_checker.sv =====
`default_nettype none
`include "banded_path_count_mod_macros.svh"

module bpc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [31:0] m_tdata,
	input wire        m_tvalid,
	input wire        m_tready
);

	import bpc_pkg::*;

	// Hold a stalled result
	`BPC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// Keep every count reduced below the modulus
	`BPC_ASSERT_SAME(a_out_range, clk, arst_n, m_tvalid, (m_tdata[31:30] == 2'b00) && (m_tdata[29:0] < MODULUS), "count not reduced")

	// Drop ready once a transaction is taken in
	`BPC_ASSERT_NEXT(a_busy_after_in, clk, arst_n, s_tvalid && s_tready, !s_tready, "ready held after input")

	// Raise a result only at the end of a sweep
	`BPC_ASSERT_SAME(a_out_after_work, clk, arst_n, $rose(m_tvalid), $past(!s_tready), "result without work")

endmodule

bind banded_path_count_mod bpc_checker u_bpc_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bpc_pkg::*;

	localparam int ROW_LEN = 128;
	// one full sweep of the row plus the pipeline around it
	localparam int SWEEP_LAT = ROW_LEN + 6;
	localparam longint unsigned PRIME = 64'd1000000007;
	localparam int HOLD_CYCLES = 3000;
	localparam int RANDOM_ITEMS = 400;

	// Directed row: optional band write before the entry, the entry itself, and a
	// hand-typed count where one is obvious.
	typedef struct packed {
		logic        set_band;
		logic [7:0]  band;
		logic [7:0]  value;
		logic        last;
		logic        typed;
		logic [29:0] count;
	} dir_row_t;

	localparam int DIR_ROWS = 24;
	//                             set   band   value    last  typed count
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// reset band of 128: single unknown, top and bottom fixed
		'{1'b0, 8'd0,   8'd0,   1'b1, 1'b1, 30'd128},
		'{1'b0, 8'd0,   8'd128, 1'b1, 1'b1, 30'd1},
		'{1'b0, 8'd0,   8'd1,   1'b1, 1'b1, 30'd1},
		// neighbouring fixed values, then a jump of three
		'{1'b0, 8'd0,   8'd5,   1'b0, 1'b0, 30'd0},
		'{1'b0, 8'd0,   8'd6,   1'b1, 1'b1, 30'd1},
		'{1'b0, 8'd0,   8'd5,   1'b0, 1'b0, 30'd0},
		'{1'b0, 8'd0,   8'd8,   1'b1, 1'b1, 30'd0},
		// two unknowns across the whole band
		'{1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 30'd0},
		'{1'b0, 8'd0,   8'd0,   1'b1, 1'b0, 30'd0},
		// unknown between two fixed ends at the lower edge
		'{1'b0, 8'd0,   8'd1,   1'b0, 1'b0, 30'd0},
		'{1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 30'd0},
		'{1'b0, 8'd0,   8'd1,   1'b1, 1'b0, 30'd0},
		// band of one: only the all-ones array survives
		'{1'b1, 8'd1,   8'd0,   1'b0, 1'b0, 30'd0},
		'{1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 30'd0},
		'{1'b0, 8'd0,   8'd0,   1'b1, 1'b1, 30'd1},
		'{1'b0, 8'd0,   8'd2,   1'b1, 1'b1, 30'd0},
		'{1'b0, 8'd0,   8'd1,   1'b1, 1'b1, 30'd1},
		// band of two: every pair is valid; a fixed value out of band kills the array
		'{1'b1, 8'd2,   8'd0,   1'b0, 1'b0, 30'd0},
		'{1'b0, 8'd0,   8'd0,   1'b1, 1'b1, 30'd4},
		'{1'b0, 8'd0,   8'd128, 1'b0, 1'b0, 30'd0},
		'{1'b0, 8'd0,   8'd0,   1'b1, 1'b1, 30'd0},
		// band of three, narrowed to two part-way through the array
		'{1'b1, 8'd3,   8'd0,   1'b0, 1'b0, 30'd0},
		'{1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 30'd0},
		'{1'b1, 8'd2,   8'd0,   1'b1, 1'b0, 30'd0}
	};

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BEAT
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] m_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = '0;

	// Predictor state
	logic [29:0] ways [ROW_LEN];
	logic        array_open;
	logic [7:0]  band;
	logic [29:0] pending_counts [$];

	int errors;
	bit hold_off_req;
	int burst_left;

	banded_path_count_mod #(
		.MAX_VALUES(ROW_LEN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),      // value [7:0]
		.s_tlast(s_tlast),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),      // count [29:0], zeros [31:30]
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #2 clk = ~clk;

	// Advance the row of counts by one entry; queue the count on the last entry
	task automatic advance_ways(input logic [7:0] v, input logic l);
		int m;
		longint unsigned s;
		longint unsigned total;
		logic [29:0] nxt [ROW_LEN];
		m = (int'(band) > ROW_LEN) ? ROW_LEN : int'(band);
		for (int k = 0; k < ROW_LEN; k++) begin
			if (!array_open) begin
				nxt[k] = (k < m) ? 30'd1 : 30'd0;
			end else begin
				s = 0;
				if (k < m) begin
					s = ways[k];
					if (k > 0)
						s += ways[k-1];
					if (k + 1 < m)
						s += ways[k+1];
					s = s % PRIME;
				end
				nxt[k] = s[29:0];
			end
			// a fixed entry keeps only its own count, and only inside the band
			if (v != 0 && (k + 1 != int'(v) || k >= m))
				nxt[k] = '0;
		end
		for (int k = 0; k < ROW_LEN; k++)
			ways[k] = nxt[k];
		array_open = !l;
		if (l) begin
			total = 0;
			if (v != 0) begin
				if (int'(v) <= m)
					total = ways[v-1];
			end else begin
				for (int k = 0; k < m; k++)
					total = (total + ways[k]) % PRIME;
			end
			pending_counts.push_back(total[29:0]);
		end
	endtask

	// Offer one entry, wait for its transaction, then idle between bursts
	task automatic send_entry(input logic [7:0] v, input logic l, input logic typed,
			input logic [29:0] typed_count);
		int gap;
		s_tdata <= v;
		s_tlast <= l;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		advance_ways(v, l);
		if (typed) begin
			void'(pending_counts.pop_back());
			pending_counts.push_back(typed_count);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 11);
			gap = ($urandom_range(0, 5) == 0) ? $urandom_range(90, 180)
				: $urandom_range(1, 20);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and hold until every queued count has come out
	task automatic drain_counts();
		s_tvalid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
	endtask

	// Write the band only once the block has gone quiet
	task automatic write_band(input logic [7:0] b);
		drain_counts();
		repeat (SWEEP_LAT + 10) @(posedge clk);
		cfg_wr_data <= b;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		band = b;
	endtask

	function automatic logic [7:0] pick_band();
		case ($urandom_range(0, 5))
			0: return 8'd1;
			1: return 8'd2;
			2: return 8'd3;
			3: return 8'd127;
			4: return 8'd128;
			default: return 8'($urandom_range(4, 126));
		endcase
	endfunction

	// Receiver: own stall pattern, with one long hold-off on request
	initial begin : receiver
		rx_mode_t mode;
		int mode_left;
		int hold_left;
		mode = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(50, 300);
				end
				mode_left--;
				case (mode)
					RX_OPEN: m_tready <= 1'b1;
					RX_COIN: m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ((mode_left % 5) < 2);
				endcase
			end
		end
	end

	// Compare each count transaction with the oldest queued count
	always @(posedge clk) begin : count_check
		logic [29:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_counts.size() == 0) begin
				$error("count: expected none, actual %0d", m_tdata[29:0]);
				errors++;
			end else begin
				want = pending_counts.pop_front();
				if (m_tdata[29:0] !== want) begin
					$error("count: expected %0d, actual %0d", want, m_tdata[29:0]);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		int sent;
		int phase_items;
		int len;
		int pos;
		int m;
		int fixed_pct;
		logic [7:0] v;
		bit noise;
		bit hold_done;
		bit pause_done;
		for (int k = 0; k < ROW_LEN; k++)
			ways[k] = '0;
		array_open = 1'b0;
		band = MAX_VALUE_RST;
		errors = 0;
		hold_off_req = 1'b0;
		burst_left = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIR_TAB[i].set_band)
				write_band(DIR_TAB[i].band);
			send_entry(DIR_TAB[i].value, DIR_TAB[i].last, DIR_TAB[i].typed, DIR_TAB[i].count);
		end

		// Random arrays: mostly walks inside the band, partly fixed, some noise
		write_band(8'd128);
		sent = 0;
		phase_items = 0;
		hold_done = 1'b0;
		pause_done = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (phase_items >= 60) begin
				write_band(pick_band());
				phase_items = 0;
			end
			if (!hold_done && sent >= 150) begin
				hold_off_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && sent >= 260) begin
				drain_counts();
				pause_done = 1'b1;
			end
			m = int'(band);
			noise = ($urandom_range(0, 7) == 0);
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 30) : $urandom_range(1, 8);
			fixed_pct = $urandom_range(0, 4) * 25;
			pos = $urandom_range(1, m);
			for (int j = 0; j < len; j++) begin
				if (noise) begin
					v = 8'($urandom_range(0, 128));
				end else begin
					if (j > 0) begin
						pos += int'($urandom_range(0, 2)) - 1;
						if (pos < 1)
							pos = 1;
						if (pos > m)
							pos = m;
					end
					v = (int'($urandom_range(1, 100)) <= fixed_pct) ? 8'(pos) : 8'd0;
					// now and then a fixed value just out of the band
					if (m < 128 && $urandom_range(0, 31) == 0)
						v = 8'($urandom_range(m + 1, 128));
				end
				send_entry(v, (j == len - 1), 1'b0, '0);
				sent++;
				phase_items++;
			end
		end

		drain_counts();
		repeat (2 * SWEEP_LAT) @(posedge clk);
		if (pending_counts.size() != 0) begin
			$error("count: %0d expected, none arrived", pending_counts.size());
			errors++;
		end
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin : watchdog
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bpc_pkg.sv
hdl/banded_path_count_mod.sv
hdl/bpc_checker.sv
tb/sv/tb_top.sv
